[hdl/pbm_pkg.sv]
package pbm_pkg;

  localparam int MAX_CHANNELS_DEF  = 8;
  localparam int OUT_FRAC_BITS_DEF = 23;
  localparam int QUEUE_DEPTH       = 4;

  // register index, byte address is four times this
  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT   = 2'd0,
    REG_VALID_BITS      = 2'd1,
    REG_SAMPLE_IS_FLOAT = 2'd2,
    REG_CONTAINER_BYTES = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_FLOAT = 3'd1,
    KIND_INT16 = 3'd2,
    KIND_INT24 = 3'd3,
    KIND_INT32 = 3'd4
  } kind_t;

  typedef struct packed {
    logic [3:0] channel_count;
    logic [5:0] valid_bits;
    logic       sample_is_float;
    logic [2:0] container_bytes;
  } cfg_t;

  // one queue entry: a finished channel sample and/or frame and packet control
  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic [2:0]  bps;
    logic        contrib;
    logic        frame_end;
    logic        emit;
    logic        silent;
    logic        halve;
    logic        clear;
  } item_t;

endpackage

[hdl/pbm_front.sv]
module pbm_front #(
  parameter int MAX_CHANNELS = pbm_pkg::MAX_CHANNELS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pbm_pkg::cfg_t  cfg,
  input  logic [7:0]     data_byte,
  input  logic           silent_packet,
  input  logic           packet_end,
  input  logic           accept,
  output logic           push,
  output pbm_pkg::item_t item
);
  import pbm_pkg::*;

  localparam int CH_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [4:0] MAX5 = 5'(MAX_CHANNELS);

  logic [1:0]      byte_position;
  logic [CH_W-1:0] channel_position;
  logic [31:0]     sample_assembly;

  logic [1:0]      byte_position_next;
  logic [CH_W-1:0] channel_position_next;
  logic [31:0]     sample_assembly_next;

  logic [4:0]  cc_ext;
  logic [4:0]  chans;
  logic        halve;
  logic [2:0]  cont;
  kind_t       kind;
  logic [2:0]  bps;
  logic [31:0] asm_cur;
  logic        done;
  logic        frame_end;
  logic        contrib;

  always_comb begin
    cc_ext = {1'b0, cfg.channel_count};
    if (cc_ext == 5'd0) begin
      chans = 5'd1;
    end else if (cc_ext > MAX5) begin
      chans = MAX5;
    end else begin
      chans = cc_ext;
    end
    halve = (chans >= 5'd2);

    if (cfg.container_bytes == 3'd0) begin
      cont = 3'd1;
    end else if (cfg.container_bytes > 3'd4) begin
      cont = 3'd4;
    end else begin
      cont = cfg.container_bytes;
    end

    if (cfg.sample_is_float) begin
      kind = (cfg.valid_bits == 6'd32) ? KIND_FLOAT : KIND_NONE;
    end else if (cfg.valid_bits == 6'd16) begin
      kind = KIND_INT16;
    end else if (cfg.valid_bits == 6'd24) begin
      kind = KIND_INT24;
    end else if (cfg.valid_bits == 6'd32) begin
      kind = KIND_INT32;
    end else begin
      kind = KIND_NONE;
    end

    case (kind)
      KIND_FLOAT, KIND_INT32: bps = 3'd4;
      KIND_INT16:             bps = 3'd2;
      default:                bps = cont;
    endcase

    asm_cur   = sample_assembly | (32'(data_byte) << {byte_position, 3'b000});
    // positions past a shrunken limit count as the end of sample or frame
    done      = ({1'b0, byte_position} + 3'd1) >= bps;
    frame_end = done && ((5'(channel_position) + 5'd1) >= chans);
    contrib   = done && (kind != KIND_NONE) &&
                (5'(channel_position) < (halve ? 5'd2 : 5'd1));

    if (done) begin
      byte_position_next    = 2'd0;
      sample_assembly_next  = 32'd0;
      channel_position_next = frame_end ? '0 : channel_position + CH_W'(1);
    end else begin
      byte_position_next    = byte_position + 2'd1;
      sample_assembly_next  = asm_cur;
      channel_position_next = channel_position;
    end
    if (packet_end) begin
      byte_position_next    = 2'd0;
      sample_assembly_next  = 32'd0;
      channel_position_next = '0;
    end

    push           = accept && (done || packet_end);
    item.word      = asm_cur;
    item.kind      = kind;
    item.bps       = bps;
    item.contrib   = contrib;
    item.frame_end = frame_end;
    item.emit      = frame_end && (silent_packet || (kind != KIND_NONE));
    item.silent    = silent_packet;
    item.halve     = halve;
    item.clear     = packet_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 2'd0;
      channel_position <= '0;
      sample_assembly  <= 32'd0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      channel_position <= channel_position_next;
      sample_assembly  <= sample_assembly_next;
    end
  end

endmodule

[hdl/pbm_fifo.sv]
module pbm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbm_pkg::item_t push_item,
  input  logic           pop,
  output pbm_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import pbm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");

endmodule

[hdl/pbm_back.sv]
module pbm_back #(
  parameter int OUT_FRAC_BITS = pbm_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pbm_pkg::item_t                    head,
  input  logic                              empty,
  output logic                              pop,
  output logic signed [OUT_FRAC_BITS+1:0]   mono_sample,
  output logic                              mono_valid,
  input  logic                              mono_stall
);
  import pbm_pkg::*;

  localparam int V_W   = OUT_FRAC_BITS + 2;
  // a float channel may reach plus two, one bit above the output width
  localparam int C_W   = OUT_FRAC_BITS + 3;
  localparam int ACC_W = OUT_FRAC_BITS + 4;
  localparam int SH24L = (OUT_FRAC_BITS >= 23) ? OUT_FRAC_BITS - 23 : 0;
  localparam int SH24R = (OUT_FRAC_BITS >= 23) ? 0 : 23 - OUT_FRAC_BITS;
  localparam logic signed [9:0] SAT_T = 10'(OUT_FRAC_BITS - 22);
  localparam logic [63:0] LIMIT = 64'd1 << (OUT_FRAC_BITS + 1);
  localparam logic signed [ACC_W-1:0] ONE = ACC_W'(64'd1 << OUT_FRAC_BITS);
  localparam logic signed [V_W-1:0] ONE_OUT = V_W'(64'd1 << OUT_FRAC_BITS);

  typedef struct packed {
    logic contrib;
    logic frame_end;
    logic emit;
    logic silent;
    logic halve;
    logic clear;
  } mix_ctl_t;

  // conversion of the head entry to the output scale
  logic signed [63:0] s24;
  logic signed [63:0] wide;
  logic               f_neg;
  logic [7:0]         f_e;
  logic [22:0]        f_frac;
  logic [23:0]        f_m;
  logic [7:0]         f_ep;
  logic signed [9:0]  f_t;
  logic [9:0]         f_sh;
  logic [63:0]        f_mag;
  logic               f_rem;
  logic               f_nan;
  logic signed [C_W-1:0] conv;

  always_comb begin
    f_neg  = head.word[31];
    f_e    = head.word[30:23];
    f_frac = head.word[22:0];
    f_m    = {(f_e != 8'd0), f_frac};
    f_ep   = (f_e == 8'd0) ? 8'd1 : f_e;
    f_t    = $signed({2'b00, f_ep}) - 10'sd150 + $signed(10'(OUT_FRAC_BITS));
    f_sh   = 10'(-f_t);
    f_rem  = 1'b0;
    f_nan  = 1'b0;
    if (f_e == 8'hFF) begin
      f_nan = (f_frac != 23'd0);
      f_mag = LIMIT;
    end else if (f_t >= SAT_T) begin
      f_mag = LIMIT;
    end else if (!f_t[9]) begin
      f_mag = 64'(f_m) << f_t[3:0];
    end else if (f_sh >= 10'd24) begin
      f_mag = 64'd0;
      f_rem = (f_m != 24'd0);
    end else begin
      f_mag = 64'(f_m) >> f_sh[4:0];
      f_rem = (f_m & ((24'd1 << f_sh[4:0]) - 24'd1)) != 24'd0;
    end
    // round toward minus infinity on the magnitude of negatives
    if (f_neg && f_rem) begin
      f_mag = f_mag + 64'd1;
    end

    if (head.bps >= 3'd4) begin
      s24 = 64'($signed(head.word)) >>> 8;
    end else if (head.bps == 3'd3) begin
      s24 = 64'($signed(head.word[23:0]));
    end else begin
      s24 = 64'sd0;
    end

    case (head.kind)
      KIND_FLOAT: begin
        if (f_nan) begin
          wide = 64'sd0;
        end else begin
          wide = f_neg ? -$signed(f_mag) : $signed(f_mag);
        end
      end
      KIND_INT16: wide = 64'($signed(head.word[15:0])) <<< (OUT_FRAC_BITS - 15);
      KIND_INT24: wide = (s24 <<< SH24L) >>> SH24R;
      KIND_INT32: wide = 64'($signed(head.word)) >>> (31 - OUT_FRAC_BITS);
      default:    wide = 64'sd0;
    endcase
    conv = C_W'(wide);
  end

  // stage a: converted sample
  logic                  a_valid;
  logic signed [C_W-1:0] a_v;
  mix_ctl_t              a_ctl;
  logic                  a_ready;
  logic                  b_take;

  // stage b: accumulator and output register
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] half;
  logic signed [ACC_W-1:0] res;

  assign b_take  = a_valid && (!a_ctl.emit || !mono_valid || !mono_stall);
  assign a_ready = !a_valid || b_take;
  assign pop     = !empty && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_v   <= conv;
      a_ctl <= '{contrib: head.contrib, frame_end: head.frame_end, emit: head.emit,
                 silent: head.silent, halve: head.halve, clear: head.clear};
    end
  end

  always_comb begin
    sum  = acc + (a_ctl.contrib ? ACC_W'(a_v) : ACC_W'(0));
    half = a_ctl.halve ? (sum >>> 1) : sum;
    if (a_ctl.silent) begin
      res = '0;
    end else if (half > ONE) begin
      res = ONE;
    end else if (half < -ONE) begin
      res = -ONE;
    end else begin
      res = half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      mono_valid <= 1'b0;
    end else begin
      if (b_take) begin
        acc <= (a_ctl.frame_end || a_ctl.clear) ? '0 : sum;
      end
      if (b_take && a_ctl.emit) begin
        mono_valid <= 1'b1;
      end else if (!mono_stall) begin
        mono_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && a_ctl.emit) begin
      mono_sample <= V_W'(res);
    end
  end

  a_out_clamped: assert property (@(posedge clk) disable iff (rst)
    mono_valid |-> (mono_sample <= ONE_OUT && mono_sample >= -ONE_OUT))
    else $error("mono sample outside plus or minus one");
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    b_take && (a_ctl.frame_end || a_ctl.clear) |=> acc == '0)
    else $error("accumulator not cleared at frame or packet end");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_ready |=> a_valid && $stable(a_v))
    else $error("converted sample lost while held");

endmodule

[hdl/pcm_bytes_to_mono_downmix_core.sv]
// a byte completing its frame is written to the queue, then taken into stage a, and its
// mono sample is registered in the stage b output register that drives mono_valid
// throughput: one byte item per cycle while byte_stall is low; no frame or packet shape adds idle cycles
// a four-entry queue between byte assembly and the mix stage absorbs output stall,
// and byte_stall rises only when that queue is full
// reset (rst, synchronous): registers to their defaults, counters, assembly,
// accumulator and queue to empty
module pcm_bytes_to_mono_downmix_core #(
  parameter int MAX_CHANNELS  = pbm_pkg::MAX_CHANNELS_DEF,
  parameter int OUT_FRAC_BITS = pbm_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic [7:0]                      data_byte,
  input  logic                            silent_packet,
  input  logic                            packet_end,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  output logic signed [OUT_FRAC_BITS+1:0] mono_sample,
  output logic                            mono_valid,
  input  logic                            mono_stall
);
  import pbm_pkg::*;

  cfg_t  cfg;
  logic  wr_en;
  logic  accept;
  logic  push;
  item_t push_item;
  item_t head;
  logic  empty;
  logic  full;
  logic  pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count   <= 4'd2;
      cfg.valid_bits      <= 6'd16;
      cfg.sample_is_float <= 1'b0;
      cfg.container_bytes <= 3'd2;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CHANNEL_COUNT:   cfg.channel_count   <= pwdata[3:0];
        REG_VALID_BITS:      cfg.valid_bits      <= pwdata[5:0];
        REG_SAMPLE_IS_FLOAT: cfg.sample_is_float <= pwdata[0];
        REG_CONTAINER_BYTES: cfg.container_bytes <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL_COUNT:   prdata = 32'(cfg.channel_count);
      REG_VALID_BITS:      prdata = 32'(cfg.valid_bits);
      REG_SAMPLE_IS_FLOAT: prdata = 32'(cfg.sample_is_float);
      REG_CONTAINER_BYTES: prdata = 32'(cfg.container_bytes);
      default:             prdata = 32'd0;
    endcase
  end

  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  pbm_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .data_byte    (data_byte),
    .silent_packet(silent_packet),
    .packet_end   (packet_end),
    .accept       (accept),
    .push         (push),
    .item         (push_item)
  );

  pbm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  pbm_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .mono_sample(mono_sample),
    .mono_valid (mono_valid),
    .mono_stall (mono_stall)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pbm_pkg::*;

  localparam int FRAC = OUT_FRAC_BITS_DEF;
  localparam int MAXCH = MAX_CHANNELS_DEF;
  localparam int STOP_AT = 650;
  localparam int CALM_AT = 540;
  localparam int DRAIN = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_PHASE = 5;
  localparam int HOLD_WORDS = 16;

  typedef logic signed [FRAC+1:0] sample_t;

  class mono_scoreboard;
    bit [3:0] chan_cnt = 4'd2;
    bit [5:0] vbits = 6'd16;
    bit is_float = 1'b0;
    bit [2:0] cont_bytes = 3'd2;
    int unsigned byte_pos;
    int unsigned chan_pos;
    bit [31:0] assembly;
    longint mix_acc;
    sample_t mono_expected[$];
    int errors;

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= 50)
        $display("mismatch %0d: %s: got %0d, expected %0d", errors, what, got, want);
    endtask

    function void set_reg(reg_idx_t idx, bit [31:0] val);
      case (idx)
        REG_CHANNEL_COUNT: chan_cnt = val[3:0];
        REG_VALID_BITS: vbits = val[5:0];
        REG_SAMPLE_IS_FLOAT: is_float = val[0];
        default: cont_bytes = val[2:0];
      endcase
    endfunction

    function int unsigned channels();
      return (chan_cnt == 0) ? 1 : ((chan_cnt > MAXCH) ? MAXCH : chan_cnt);
    endfunction

    function kind_t fmt_kind();
      if (is_float) return (vbits == 32) ? KIND_FLOAT : KIND_NONE;
      if (vbits == 16) return KIND_INT16;
      if (vbits == 24) return KIND_INT24;
      if (vbits == 32) return KIND_INT32;
      return KIND_NONE;
    endfunction

    function int unsigned bytes_per_sample();
      kind_t k;
      k = fmt_kind();
      if (k == KIND_FLOAT || k == KIND_INT32) return 4;
      if (k == KIND_INT16) return 2;
      return (cont_bytes == 0) ? 1 : ((cont_bytes > 4) ? 4 : cont_bytes);
    endfunction

    // floor rescale of a fixed-point value to the output fraction width
    function longint rescale(longint v, int from_frac);
      if (FRAC >= from_frac) return v <<< (FRAC - from_frac);
      return v >>> (from_frac - FRAC);
    endfunction

    function int pending();
      return mono_expected.size();
    endfunction

    function void note_byte(bit [7:0] b, bit silent, bit pend);
      int unsigned chans, mixed, bps;
      kind_t kind;
      longint v, r, one;
      longint unsigned mag, mant, lim;
      int expo, sh;
      chans = channels();
      mixed = (chans > 2) ? 2 : chans;
      kind = fmt_kind();
      bps = bytes_per_sample();
      lim = 64'd1 << (FRAC + 1);
      one = 64'sd1 <<< FRAC;
      assembly |= 32'(b) << (8 * (byte_pos & 3));
      if (byte_pos + 1 >= bps) begin
        if (chan_pos < mixed && kind != KIND_NONE) begin
          case (kind)
            KIND_FLOAT: begin
              expo = assembly[30:23];
              mant = assembly[22:0];
              if (expo == 255) begin
                mag = (mant != 0) ? 0 : lim;
              end else begin
                if (expo != 0) mant = mant | 64'h80_0000;
                sh = ((expo != 0) ? expo : 1) - 150 + FRAC;
                if (sh >= 0) begin
                  mag = (sh > 40) ? lim : (mant << sh);
                end else if (-sh >= 63) begin
                  mag = (assembly[31] && mant != 0) ? 1 : 0;
                end else begin
                  mag = mant >> (-sh);
                  // negative values round toward minus infinity
                  if (assembly[31] && (mant & ((64'd1 << (-sh)) - 1)) != 0) mag++;
                end
                if (mag > lim) mag = lim;
              end
              v = assembly[31] ? -longint'(mag) : longint'(mag);
            end
            KIND_INT16: v = rescale(longint'($signed(assembly[15:0])), 15);
            KIND_INT24: begin
              if (bps >= 4) v = rescale(longint'($signed(assembly)) >>> 8, 23);
              else if (bps == 3) v = rescale(longint'($signed(assembly[23:0])), 23);
              else v = 0;
            end
            default: v = rescale(longint'($signed(assembly)), 31);
          endcase
          mix_acc += v;
        end
        assembly = 0;
        byte_pos = 0;
        chan_pos++;
        if (chan_pos >= chans) begin
          if (silent || kind != KIND_NONE) begin
            r = 0;
            if (!silent) begin
              r = (mixed == 2) ? (mix_acc >>> 1) : mix_acc;
              if (r > one) r = one;
              if (r < -one) r = -one;
            end
            mono_expected.push_back(sample_t'(r));
          end
          mix_acc = 0;
          chan_pos = 0;
        end
      end else begin
        byte_pos++;
      end
      if (pend) begin
        byte_pos = 0;
        chan_pos = 0;
        assembly = 0;
        mix_acc = 0;
      end
    endfunction

    task check_mono(sample_t got);
      sample_t want;
      if (mono_expected.size() == 0) begin
        report("mono item with nothing pending", longint'(got), 0);
      end else begin
        want = mono_expected.pop_front();
        if (got !== want) report("mono_sample", longint'(got), longint'(want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic [7:0] data_byte;
  logic silent_packet, packet_end, byte_valid, byte_stall;
  sample_t mono_sample;
  logic mono_valid, mono_stall;

  mono_scoreboard sb;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;
  int unsigned bytes_sent = 0;
  int quiet_cycles = 0;

  pcm_bytes_to_mono_downmix_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .data_byte(data_byte), .silent_packet(silent_packet), .packet_end(packet_end),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .mono_sample(mono_sample), .mono_valid(mono_valid), .mono_stall(mono_stall)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (byte_valid && !byte_stall) sb.note_byte(data_byte, silent_packet, packet_end);
      if (mono_valid && !mono_stall) sb.check_mono(mono_sample);
      quiet_cycles <= ((byte_valid && !byte_stall) || (mono_valid && !mono_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // output side: random stall bursts, quiet stretches, and one long hold-off
  initial begin : mono_stall_gen
    int n;
    mono_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        mono_stall <= 1'b1;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        mono_stall <= 1'b0;
        holding = 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        mono_stall <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
        mono_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 29) == 0) begin
        n = $urandom_range(30, 120);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic reg_read(reg_idx_t idx, bit [31:0] want);
    bit [31:0] got;
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= 4'(int'(idx) << 2);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== want) sb.report("register read-back", got, want);
  endtask

  task automatic reg_write(reg_idx_t idx, bit [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(int'(idx) << 2);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
    @(negedge clk);
    reg_read(idx, val);
  endtask

  task automatic apply_config(bit [3:0] ch, bit [5:0] vb, bit fl, bit [2:0] cb);
    reg_write(REG_CHANNEL_COUNT, 32'(ch));
    reg_write(REG_VALID_BITS, 32'(vb));
    reg_write(REG_SAMPLE_IS_FLOAT, 32'(fl));
    reg_write(REG_CONTAINER_BYTES, 32'(cb));
  endtask

  task automatic push_byte(bit [7:0] b, bit silent, bit pend);
    int gap;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    silent_packet <= silent;
    packet_end <= pend;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_word(bit [31:0] w, int unsigned nb, bit silent, bit pend);
    for (int unsigned i = 0; i < nb; i++)
      push_byte(w[8 * i +: 8], silent, pend && i == nb - 1);
  endtask

  // stop offering items and let every pending mono item and the pipeline drain
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic bit [31:0] pick_word(kind_t k, int unsigned nb);
    bit [31:0] w, lo;
    int r;
    w = $urandom;
    r = $urandom_range(0, 9);
    if (k == KIND_FLOAT) begin
      if (r < 3) begin
        case ($urandom_range(0, 11))
          0: w = 32'h7FC0_0000;
          1: w = 32'hFF80_0001;
          2: w = 32'h7F80_0000;
          3: w = 32'hFF80_0000;
          4: w = 32'h4020_0000;
          5: w = 32'hC020_0000;
          6: w = 32'h3F80_0000;
          7: w = 32'hBF80_0000;
          8: w = 32'h0000_0001;
          9: w = 32'h8000_0001;
          10: w = 32'h8000_0000;
          default: w = 32'hBF7F_FFFF;
        endcase
      end else if (r < 9) begin
        w = {w[31], 8'($urandom_range(100, 128)), w[22:0]};
      end
    end else begin
      lo = 32'd1 << (8 * nb - 1);
      if (r == 0) w = lo;
      else if (r == 1) w = lo - 1;
      else if (r == 2) w = '0;
      else if (r == 3) w = '1;
    end
    return w;
  endfunction

  // one packet of whole frames; some end early, some carry no end flag at all
  task automatic send_packet(int unsigned frames, bit silent);
    int unsigned nb, total, cut;
    bit no_end;
    bit [31:0] w;
    nb = sb.bytes_per_sample();
    total = frames * sb.channels() * nb;
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total - 1;
    no_end = ($urandom_range(0, 7) == 0);
    for (int unsigned i = 0; i <= cut; i++) begin
      if (i % nb == 0) w = pick_word(sb.fmt_kind(), nb);
      push_byte(w[8 * (i % nb) +: 8], silent ^ ($urandom_range(0, 29) == 0),
                i == cut && !no_end);
    end
  endtask

  task automatic pick_config(int unsigned phase);
    bit [3:0] ch;
    bit [5:0] vb;
    bit fl;
    bit [2:0] cb;
    ch = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 2));
    cb = 3'($urandom_range(2, 4));
    fl = 1'b0;
    case ($urandom_range(0, 9))
      0, 1: vb = 6'd16;
      2, 3: vb = 6'd24;
      4: begin
        vb = 6'd24;
        cb = 3'($urandom);
      end
      5, 6: vb = 6'd32;
      7, 8: begin
        vb = 6'd32;
        fl = 1'b1;
      end
      default: begin
        vb = 6'($urandom);
        fl = 1'($urandom);
        cb = 3'($urandom);
      end
    endcase
    // register extremes early on
    case (phase)
      0: begin ch = 4'd8; vb = 6'd24; fl = 1'b0; cb = 3'd4; end
      1: begin ch = 4'd15; vb = 6'd32; fl = 1'b0; cb = 3'd7; end
      2: begin ch = 4'd0; vb = 6'd63; fl = 1'b1; cb = 3'd0; end
      3: begin ch = 4'd1; vb = 6'd16; fl = 1'b1; cb = 3'd1; end
      4: begin ch = 4'd3; vb = 6'd0; fl = 1'b0; cb = 3'd3; end
      HOLD_PHASE: begin ch = 4'd1; vb = 6'd16; fl = 1'b0; end
      default: ;
    endcase
    apply_config(ch, vb, fl, cb);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned npk;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    data_byte = '0;
    silent_packet = 1'b0;
    packet_end = 1'b0;
    byte_valid = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    reg_read(REG_CHANNEL_COUNT, 32'd2);
    reg_read(REG_VALID_BITS, 32'd16);
    reg_read(REG_SAMPLE_IS_FLOAT, 32'd0);
    reg_read(REG_CONTAINER_BYTES, 32'd2);

    // int16 stereo from reset: full scale both ways, silent frame, cut frame
    push_word(32'h8000_8000, 4, 1'b0, 1'b0);
    push_word(32'h7FFF_7FFF, 4, 1'b0, 1'b0);
    push_word(32'h7FFF_8000, 4, 1'b1, 1'b0);
    push_word(32'h0000_1234, 2, 1'b0, 1'b1);
    wait_idle();
    // float stereo: infinity saturates and clamps, negative subnormal rounds down
    apply_config(4'd2, 6'd32, 1'b1, 3'd4);
    push_word(32'h7F80_0000, 4, 1'b0, 1'b0);
    push_word(32'h8000_0001, 4, 1'b0, 1'b0);
    push_word(32'h7FC0_0000, 4, 1'b0, 1'b0);
    push_word(32'hFF80_0000, 4, 1'b0, 1'b1);
    wait_idle();

    phase = 0;
    while (bytes_sent < STOP_AT) begin
      pick_config(phase);
      if (phase == HOLD_PHASE) begin
        hold_req = 1'b1;
        wait (holding);
        // keep offering through the hold-off so the queue fills and stalls the input
        repeat (HOLD_WORDS) push_word(pick_word(KIND_INT16, 2), 2, 1'b0, 1'b0);
      end
      npk = $urandom_range(2, 4);
      repeat (npk) begin
        send_packet((sb.channels() * sb.bytes_per_sample() > 8) ?
                    $urandom_range(1, 2) : $urandom_range(1, 5),
                    $urandom_range(0, 5) == 0);
      end
      wait_idle();
      if (bytes_sent >= CALM_AT) calm = 1'b1;
      phase++;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pbm_pkg.sv
hdl/pbm_front.sv
hdl/pbm_fifo.sv
hdl/pbm_back.sv
hdl/pcm_bytes_to_mono_downmix_core.sv
tb/tb_top.sv
